// ----- src/ring_fifo_with_iterator_assert.svh -----
`ifndef RING_FIFO_WITH_ITERATOR_ASSERT_SVH
`define RING_FIFO_WITH_ITERATOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define RFI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ring fifo check failed");

// next-cycle implication, sampled on clk, off during reset
`define RFI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ring fifo check failed");

`endif

// ----- src/rfi_pkg.sv -----
package rfi_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int IDENT_BITS_DEF = 8;

  localparam int KIND_W   = 3;
  localparam int VALUE_W  = 8;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  localparam logic [KIND_W-1:0] KIND_ENQ        = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DEQ        = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PEEK       = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ITER_START = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ITER_NEXT  = 3'd4;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [7:0]        ident;
  } req_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]    occupancy;
  } rsp_t;

  typedef struct packed {
    logic                done;
    logic                sel;
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]    occupancy;
  } ctl_res_t;

endpackage

// ----- src/ring_fifo_with_iterator.sv -----
// Circular queue of task identifiers with a read cursor. A request is taken
// when start is high and busy is low; its result appears on rsp with done
// high for exactly one cycle, the cycle after the request, and the receiver
// cannot stall it. Each request keeps busy high for that one result cycle,
// so the block cannot take a new request before the last one's result is
// out; the result waits on the registered read of the slot memory. After
// reset the slot memory is cleared one entry per cycle, and busy stays high
// until every entry is cleared, so no request is taken before then.
module ring_fifo_with_iterator #(
  parameter int DEPTH      = rfi_pkg::DEPTH_DEF,
  parameter int IDENT_BITS = rfi_pkg::IDENT_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  rfi_pkg::req_t req,
  output logic          busy,
  output logic          done,
  output rfi_pkg::rsp_t rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int VW = rfi_pkg::VALUE_W;

  rfi_pkg::ctl_res_t res;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [IDENT_BITS-1:0] mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [IDENT_BITS-1:0] mem_rdata;

  rfi_ctrl #(
    .DEPTH      (DEPTH),
    .IDENT_BITS (IDENT_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req       (req),
    .busy      (busy),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr)
  );

  rfi_ram #(
    .WIDTH (IDENT_BITS),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign done          = res.done;
  assign rsp.value     = res.sel ? VW'(mem_rdata) : '0;
  assign rsp.status    = res.status;
  assign rsp.occupancy = res.occupancy;

endmodule

// ----- src/rfi_ram.sv -----
module rfi_ram #(
  parameter int WIDTH = rfi_pkg::IDENT_BITS_DEF,
  parameter int DEPTH = rfi_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/rfi_ctrl.sv -----
module rfi_ctrl #(
  parameter int DEPTH      = rfi_pkg::DEPTH_DEF,
  parameter int IDENT_BITS = rfi_pkg::IDENT_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  rfi_pkg::req_t            req,
  output logic                     busy,
  output rfi_pkg::ctl_res_t        res,
  output logic                     mem_we,
  output logic [$clog2(DEPTH)-1:0] mem_waddr,
  output logic [IDENT_BITS-1:0]    mem_wdata,
  output logic [$clog2(DEPTH)-1:0] mem_raddr
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int OW = rfi_pkg::OCC_W;
  localparam int IW = IDENT_BITS;

  rfi_pkg::state_t state, state_next;

  logic [AW-1:0] head, head_next;
  logic [AW-1:0] tail, tail_next;
  logic [CW-1:0] fill, fill_next;
  logic [AW-1:0] cursor, cursor_next;
  logic [CW-1:0] visited, visited_next;
  logic [AW-1:0] clr;

  logic                         done;
  logic                         sel, sel_next;
  logic [rfi_pkg::STATUS_W-1:0] status, status_next;
  logic [OW-1:0]                occ;

  logic          accept;
  logic          op_we;
  logic [AW-1:0] op_waddr;
  logic [AW-1:0] op_raddr;

  function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] i);
    return (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  assign accept = start && !busy;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      rfi_pkg::S_CLEAR: begin
        if (clr == AW'(DEPTH - 1)) begin
          state_next = rfi_pkg::S_IDLE;
        end
      end
      rfi_pkg::S_IDLE: begin
        if (start) begin
          state_next = rfi_pkg::S_EXEC;
        end
      end
      rfi_pkg::S_EXEC: state_next = rfi_pkg::S_IDLE;
      default:         state_next = rfi_pkg::S_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    busy = 1'b1;
    done = 1'b0;
    unique case (state)
      rfi_pkg::S_CLEAR: busy = 1'b1;
      rfi_pkg::S_IDLE:  busy = 1'b0;
      rfi_pkg::S_EXEC:  done = 1'b1;
      default:          busy = 1'b1;
    endcase
  end

  assign res = {done, sel, status, occ};

  // operation decode on request
  always_comb begin
    head_next    = head;
    tail_next    = tail;
    fill_next    = fill;
    cursor_next  = cursor;
    visited_next = visited;
    sel_next     = 1'b0;
    status_next  = rfi_pkg::STAT_OK;
    op_we        = 1'b0;
    op_waddr     = '0;
    op_raddr     = head;
    unique case (req.kind)
      rfi_pkg::KIND_ENQ: begin
        if (fill == CW'(DEPTH)) begin
          status_next = rfi_pkg::STAT_FULL;
        end else if (fill == '0) begin
          op_we     = 1'b1;
          op_waddr  = '0;
          head_next = '0;
          tail_next = '0;
          fill_next = CW'(1);
        end else begin
          op_we     = 1'b1;
          op_waddr  = next_idx(tail);
          tail_next = next_idx(tail);
          fill_next = fill + 1'b1;
        end
      end
      rfi_pkg::KIND_DEQ: begin
        if (fill == '0) begin
          status_next = rfi_pkg::STAT_EMPTY;
        end else begin
          sel_next  = 1'b1;
          fill_next = fill - 1'b1;
          if (fill == CW'(1)) begin
            head_next = '0;
            tail_next = '0;
          end else begin
            head_next = next_idx(head);
          end
        end
      end
      rfi_pkg::KIND_PEEK: begin
        sel_next    = 1'b1;
        status_next = (fill == '0) ? rfi_pkg::STAT_EMPTY : rfi_pkg::STAT_OK;
      end
      rfi_pkg::KIND_ITER_START: begin
        if (fill == '0) begin
          status_next = rfi_pkg::STAT_EMPTY;
        end else begin
          sel_next     = 1'b1;
          cursor_next  = head;
          visited_next = CW'(1);
        end
      end
      rfi_pkg::KIND_ITER_NEXT: begin
        if (visited >= fill) begin
          status_next = rfi_pkg::STAT_EMPTY;
        end else begin
          sel_next     = 1'b1;
          op_raddr     = next_idx(cursor);
          cursor_next  = next_idx(cursor);
          visited_next = visited + 1'b1;
        end
      end
      default: begin
        status_next = rfi_pkg::STAT_OK;
      end
    endcase
  end

  // memory port: clearing sweep after reset, else the accepted request
  always_comb begin
    mem_raddr = op_raddr;
    if (state == rfi_pkg::S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr;
      mem_wdata = '0;
    end else begin
      mem_we    = accept && op_we;
      mem_waddr = op_waddr;
      mem_wdata = IW'(req.ident);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= rfi_pkg::S_CLEAR;
      clr     <= '0;
      head    <= '0;
      tail    <= '0;
      fill    <= '0;
      cursor  <= '0;
      visited <= '0;
      sel     <= 1'b0;
      status  <= rfi_pkg::STAT_OK;
      occ     <= '0;
    end else begin
      state <= state_next;
      if (state == rfi_pkg::S_CLEAR) begin
        clr <= clr + 1'b1;
      end
      if (accept) begin
        head    <= head_next;
        tail    <= tail_next;
        fill    <= fill_next;
        cursor  <= cursor_next;
        visited <= visited_next;
        sel     <= sel_next;
        status  <= status_next;
        occ     <= OW'(fill_next);
      end
    end
  end

endmodule

// ----- src/rfi_checker.sv -----
`include "ring_fifo_with_iterator_assert.svh"

module rfi_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input rfi_pkg::req_t req,
  input logic          busy,
  input logic          done,
  input rfi_pkg::rsp_t rsp
);

  `RFI_ASSERT_NXT(a_result_follows, start && !busy, done)
  `RFI_ASSERT_NXT(a_single_result, done, !done)
  `RFI_ASSERT_IMP(a_busy_with_result, done, busy)
  `RFI_ASSERT_IMP(a_status_code, done, rsp.status != 2'd3)
  `RFI_ASSERT_IMP(a_refused_no_value, done && rsp.status == rfi_pkg::STAT_FULL, rsp.value == '0)

endmodule

bind ring_fifo_with_iterator rfi_checker u_rfi_checker (.*);
